// ===== rtl/bpblit_pkg.sv =====
`default_nettype none

package bpblit_pkg;

   // Geometry of one framebuffer cell.
   localparam int WORD_BITS           = 16;
   localparam int MAX_PLANES          = 4;
   localparam int CELL_BITS           = WORD_BITS * MAX_PLANES;
   localparam int MASK_BITS           = 2 * WORD_BITS;
   localparam int SHIFT_BITS          = 4;
   localparam int ROW_BITS            = 15;
   localparam int PLANE_COUNT_DEFAULT = 4;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = ROW_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SHIFT       = 2'd0,
      CSR_CELL_SELECT = 2'd1,
      CSR_MODE        = 2'd2,
      CSR_ROW_COUNT   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_BOTH     = 2'd0,
      SEL_TRAILING = 2'd1,
      SEL_LEADING  = 2'd2,
      SEL_NONE     = 2'd3
   } cell_select_type;

   typedef struct packed {
      logic [MASK_BITS-1:0] mask_word;
      logic [CELL_BITS-1:0] plane_data;
      logic [CELL_BITS-1:0] dest_leading;
      logic [CELL_BITS-1:0] dest_trailing;
   } req_payload_type;

   typedef struct packed {
      logic [CELL_BITS-1:0] new_leading;
      logic [CELL_BITS-1:0] new_trailing;
      logic                 write_leading;
      logic                 write_trailing;
      logic [ROW_BITS-1:0]  row_index;
      logic                 last_row;
   } rsp_payload_type;

   // Controls shared by both cell blenders.
   typedef struct packed {
      logic                  enable;
      logic                  draw;
      logic [SHIFT_BITS-1:0] shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/bpblit_cell.sv =====
`default_nettype none

// Masks and optionally colours every active plane of one cell while enabled; else passes it.
module bpblit_cell
   import bpblit_pkg::*;
#(
   parameter int PLANE_COUNT = PLANE_COUNT_DEFAULT,
   parameter bit LEADING     = 1'b0
) (
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [WORD_BITS-1:0] mask,
   input  wire logic [CELL_BITS-1:0] data,
   input  wire logic [CELL_BITS-1:0] dest,
   output logic      [CELL_BITS-1:0] result
);

   for (genvar p = 0; p < MAX_PLANES; p++) begin : g_plane
      if (p < PLANE_COUNT) begin : g_active
         logic [MASK_BITS-1:0] spread;
         logic [WORD_BITS-1:0] colour;
         logic [WORD_BITS-1:0] word;

         always_comb begin
            spread = {data[p*WORD_BITS +: WORD_BITS], {WORD_BITS{1'b0}}} >> ctrl.shift;
            colour = LEADING ? spread[MASK_BITS-1:WORD_BITS] : spread[WORD_BITS-1:0];
            word   = dest[p*WORD_BITS +: WORD_BITS] & mask;
            if (ctrl.draw) begin
               word = word | colour;
            end
         end

         assign result[p*WORD_BITS +: WORD_BITS] =
            ctrl.enable ? word : dest[p*WORD_BITS +: WORD_BITS];
      end else begin : g_idle
         // Planes beyond the configured count are left as they are.
         assign result[p*WORD_BITS +: WORD_BITS] = dest[p*WORD_BITS +: WORD_BITS];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bitplane_mask_and_or_row_blit_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_payload_type (mask, colour, two cells)
// rsp       out        rsp_valid / rsp_stall   rsp_payload_type (two cells, flags, row)
// csr       in         csr_write               csr_index, csr_data
//
// One item is accepted per cycle when not stalled; a drawn row's result appears in the
// output register in the next cycle. The path is a 32-bit rotate, a 32-bit shift per plane
// and an AND/OR per plane. Synchronous reset clears the configuration, the row counter and
// the output valid. The input stalls only while a result sits in the output register and
// the output is stalled, so a new item is taken in the same cycle the old result leaves.
module bitplane_mask_and_or_row_blit_unit
   import bpblit_pkg::*;
#(
   parameter int PLANE_COUNT = PLANE_COUNT_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,

   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire req_payload_type            req_payload,

   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output rsp_payload_type                 rsp_payload,

   input  wire                             csr_write,
   input  wire       [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire       [CSR_DATA_BITS-1:0]   csr_data
);

   // Configuration registers.
   logic [SHIFT_BITS-1:0] shift_ff;
   logic [1:0]            cell_select_ff;
   logic                  mode_ff;
   logic [ROW_BITS-1:0]   row_count_ff;

   // Rows of the current sprite already drawn.
   logic [ROW_BITS-1:0]   rows_done_ff;
   logic [ROW_BITS-1:0]   rows_done_in;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_payload_type       rsp_payload_ff;
   rsp_payload_type       rsp_payload_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  row_live;
   logic [ROW_BITS:0]     rows_next;
   logic [MASK_BITS-1:0]  mask_rot;
   logic [2*MASK_BITS-1:0] mask_pair;
   cell_ctrl_type         lead_ctrl;
   cell_ctrl_type         trail_ctrl;
   logic [CELL_BITS-1:0]  lead_cell;
   logic [CELL_BITS-1:0]  trail_cell;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !out_free;
   assign req_accept = req_valid && out_free;

   // A row is drawn only while the counter is below the configured count.
   assign row_live  = rows_done_ff < row_count_ff;
   assign rows_next = {1'b0, rows_done_ff} + {{ROW_BITS{1'b0}}, 1'b1};

   // Rotate right of the mask: the high half feeds the leading cell.
   assign mask_pair = {req_payload.mask_word, req_payload.mask_word} >> shift_ff;
   assign mask_rot  = mask_pair[MASK_BITS-1:0];

   always_comb begin
      lead_ctrl.enable  = (cell_select_ff == SEL_BOTH) || (cell_select_ff == SEL_LEADING);
      lead_ctrl.draw    = mode_ff;
      lead_ctrl.shift   = shift_ff;
      trail_ctrl.enable = (cell_select_ff == SEL_BOTH) || (cell_select_ff == SEL_TRAILING);
      trail_ctrl.draw   = mode_ff;
      trail_ctrl.shift  = shift_ff;
   end

   bpblit_cell #(
      .PLANE_COUNT (PLANE_COUNT),
      .LEADING     (1'b1)
   ) u_lead (
      .ctrl   (lead_ctrl),
      .mask   (mask_rot[MASK_BITS-1:WORD_BITS]),
      .data   (req_payload.plane_data),
      .dest   (req_payload.dest_leading),
      .result (lead_cell)
   );

   bpblit_cell #(
      .PLANE_COUNT (PLANE_COUNT),
      .LEADING     (1'b0)
   ) u_trail (
      .ctrl   (trail_ctrl),
      .mask   (mask_rot[WORD_BITS-1:0]),
      .data   (req_payload.plane_data),
      .dest   (req_payload.dest_trailing),
      .result (trail_cell)
   );

   always_comb begin
      rsp_payload_in.new_leading    = lead_cell;
      rsp_payload_in.new_trailing   = trail_cell;
      rsp_payload_in.write_leading  = lead_ctrl.enable;
      rsp_payload_in.write_trailing = trail_ctrl.enable;
      rsp_payload_in.row_index      = rows_done_ff;
      rsp_payload_in.last_row       = rows_next == {1'b0, row_count_ff};

      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = req_accept && row_live;
      end

      // Writing the row count restarts the sprite.
      rows_done_in = rows_done_ff;
      if (csr_write && csr_index == CSR_ROW_COUNT) begin
         rows_done_in = '0;
      end else if (req_accept && row_live) begin
         rows_done_in = rows_next[ROW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff       <= '0;
         cell_select_ff <= SEL_BOTH;
         mode_ff        <= 1'b0;
         row_count_ff   <= '0;
         rows_done_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rows_done_ff <= rows_done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SHIFT:       shift_ff       <= csr_data[SHIFT_BITS-1:0];
               CSR_CELL_SELECT: cell_select_ff <= csr_data[1:0];
               CSR_MODE:        mode_ff        <= csr_data[0];
               CSR_ROW_COUNT:   row_count_ff   <= csr_data[ROW_BITS-1:0];
               default:         ;
            endcase
         end
      end
   end

   // The payload register loads only when a drawn row is accepted.
   always_ff @(posedge clock) begin
      if (req_accept && row_live) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The counter never passes the configured count.
   a_rows_bounded: assert property (@(posedge clock) disable iff (reset)
      rows_done_ff <= row_count_ff)
      else $error("row counter ran past the row count");

   // A drawn row shows up next cycle carrying the counter value it was accepted with.
   a_row_index: assert property (@(posedge clock) disable iff (reset)
      req_accept && row_live |=> rsp_valid && rsp_payload.row_index == $past(rows_done_ff))
      else $error("accepted row missing or carries wrong index");

   // A dropped row leaves the counter alone unless the count is rewritten.
   a_drop_hold: assert property (@(posedge clock) disable iff (reset)
      req_accept && !row_live && !(csr_write && csr_index == CSR_ROW_COUNT)
      |=> $stable(rows_done_ff))
      else $error("dropped row moved the row counter");

endmodule

`default_nettype wire
